>>> design/gffba_pkg.sv
// ----------------------------------------------------------------------------
// gffba_pkg
// Shared field widths, action codes and register indexes of the grid
// first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gffba_pkg;

    localparam int ACTION_W     = 2;
    localparam int BLK_ROWS_W   = 5;
    localparam int BLK_COLS_W   = 3;
    localparam int OWNER_W      = 8;
    localparam int QUERY_ROW_W  = 4;
    localparam int QUERY_COL_W  = 2;
    localparam int PLACE_ROW_W  = 4;
    localparam int PLACE_COL_W  = 2;
    localparam int ROWS_CFG_W   = 5;
    localparam int COLS_CFG_W   = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd16;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 3'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PLACE = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROWS_IN_USE = 1'd0,
        CFG_COLS_IN_USE = 1'd1
    } t_cfg_index;

endpackage

`default_nettype wire

>>> design/gffba_fit_unit.sv
// ----------------------------------------------------------------------------
// gffba_fit_unit
// One row step of the placement scan: updates the free-run length of every
// column and finds the leftmost column where the block ends on this row.
// ----------------------------------------------------------------------------
`default_nettype none

module gffba_fit_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 4,
    localparam int RUN_W   = $clog2(MAX_ROWS + 1),
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int NC_W    = $clog2(MAX_COLS + 1)
) (
    input  wire logic [MAX_COLS-1:0]                    i_occ,
    input  wire logic [MAX_COLS-1:0][RUN_W-1:0]         i_run,
    input  wire logic [gffba_pkg::BLK_ROWS_W-1:0]       i_blk_rows,
    input  wire logic [gffba_pkg::BLK_COLS_W-1:0]       i_blk_cols,
    input  wire logic [NC_W-1:0]                        i_area_cols,
    output logic      [MAX_COLS-1:0][RUN_W-1:0]         o_run,
    output logic                                        o_hit,
    output logic      [COL_W-1:0]                       o_hit_col
);

    logic [MAX_COLS-1:0] tall;
    logic [MAX_COLS-1:0] fits;

    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            o_run[j] = i_occ[j] ? '0 : i_run[j] + RUN_W'(1);
            tall[j]  = 32'(o_run[j]) >= 32'(i_blk_rows);
        end
        for (int c = 0; c < MAX_COLS; c++) begin
            fits[c] = (32'(c) + 32'(i_blk_cols)) <= 32'(i_area_cols);
            for (int j = 0; j < MAX_COLS; j++) begin
                if ((j >= c) && (32'(j) < 32'(c) + 32'(i_blk_cols)) && !tall[j]) begin
                    fits[c] = 1'b0;
                end
            end
        end
        o_hit     = |fits;
        o_hit_col = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--) begin
            if (fits[c]) begin
                o_hit_col = COL_W'(c);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/grid_first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// grid_first_fit_block_allocator_unit
// Occupancy grid of owner ids with first-fit placement of rectangular blocks,
// clear of all cells and query of one cell.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_stall     action, block size, owner, query cell
//  out      output     o_out_valid / i_out_stall   found, place row/col, cell owner
//  cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
//  clear and unused action: straight to the done state; query: a read state first
//  place: scans rows up to rows_in_use (at most MAX_ROWS), fills the block if it fits,
//  one grid row per cycle through the shared row fit unit, then one row write
//  reset and register writes free the grid at once through per-row valid bits
//  one word in flight; the result register frees the input side while it waits
// ----------------------------------------------------------------------------
`default_nettype none

module grid_first_fit_block_allocator_unit #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 4,
    parameter int OWNER_BITS = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [gffba_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [gffba_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [gffba_pkg::ACTION_W-1:0]         i_action,
    input  wire logic [gffba_pkg::BLK_ROWS_W-1:0]       i_blk_rows,
    input  wire logic [gffba_pkg::BLK_COLS_W-1:0]       i_blk_cols,
    input  wire logic [gffba_pkg::OWNER_W-1:0]          i_owner_id,
    input  wire logic [gffba_pkg::QUERY_ROW_W-1:0]      i_query_row,
    input  wire logic [gffba_pkg::QUERY_COL_W-1:0]      i_query_col,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_found,
    output logic      [gffba_pkg::PLACE_ROW_W-1:0]      o_place_row,
    output logic      [gffba_pkg::PLACE_COL_W-1:0]      o_place_col,
    output logic      [gffba_pkg::OWNER_W-1:0]          o_cell_owner
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RUN_W = $clog2(MAX_ROWS + 1);
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_QUERY,
        S_DONE
    } t_state;

    t_state                                     r_state;
    logic [gffba_pkg::ROWS_CFG_W-1:0]           r_rows_in_use;
    logic [gffba_pkg::COLS_CFG_W-1:0]           r_cols_in_use;
    logic [MAX_ROWS-1:0][MAX_COLS-1:0]          r_occ;
    logic [MAX_ROWS-1:0]                        r_row_vld;
    logic [MAX_COLS-1:0][OWNER_BITS-1:0]        r_owner_mem [MAX_ROWS];
    logic [MAX_COLS-1:0][OWNER_BITS-1:0]        r_rd_data;
    logic                                       r_rd_vld;

    logic [ROW_W-1:0]                           r_row;
    logic [ROW_W-1:0]                           r_end;
    logic [COL_W-1:0]                           r_col;
    logic [MAX_COLS-1:0][RUN_W-1:0]             r_run;
    logic [gffba_pkg::BLK_ROWS_W-1:0]           r_rs;
    logic [gffba_pkg::BLK_COLS_W-1:0]           r_cs;
    logic [OWNER_BITS-1:0]                      r_owner;
    logic [gffba_pkg::QUERY_COL_W-1:0]          r_qcol;
    logic                                       r_qin;

    logic                                       r_res_found;
    logic [gffba_pkg::PLACE_ROW_W-1:0]          r_res_row;
    logic [gffba_pkg::PLACE_COL_W-1:0]          r_res_col;
    logic [gffba_pkg::OWNER_W-1:0]              r_res_owner;

    logic                                       r_out_valid;
    logic                                       r_out_found;
    logic [gffba_pkg::PLACE_ROW_W-1:0]          r_out_row;
    logic [gffba_pkg::PLACE_COL_W-1:0]          r_out_col;
    logic [gffba_pkg::OWNER_W-1:0]              r_out_owner;

    logic [NR_W-1:0]                            area_rows;
    logic [NC_W-1:0]                            area_cols;
    logic                                       in_accept;
    logic                                       out_take;
    logic [MAX_COLS-1:0][RUN_W-1:0]             n_run;
    logic                                       hit;
    logic [COL_W-1:0]                           hit_col;
    logic [ROW_W-1:0]                           hit_top;
    logic [MAX_COLS-1:0]                        fill_mask;
    logic [MAX_COLS-1:0]                        fill_we;
    logic [ROW_W-1:0]                           rd_addr;
    logic [OWNER_BITS-1:0]                      query_owner;

    assign area_rows = (32'(r_rows_in_use) > MAX_ROWS) ? NR_W'(MAX_ROWS)
                                                       : NR_W'(r_rows_in_use);
    assign area_cols = (32'(r_cols_in_use) > MAX_COLS) ? NC_W'(MAX_COLS)
                                                       : NC_W'(r_cols_in_use);

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_place_row  = r_out_row;
    assign o_place_col  = r_out_col;
    assign o_cell_owner = r_out_owner;

    gffba_fit_unit #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_fit (
        .i_occ       (r_occ[r_row]),
        .i_run       (r_run),
        .i_blk_rows  (r_rs),
        .i_blk_cols  (r_cs),
        .i_area_cols (area_cols),
        .o_run       (n_run),
        .o_hit       (hit),
        .o_hit_col   (hit_col)
    );

    assign hit_top = ROW_W'(32'(r_row) + 32'd1 - 32'(r_rs));
    assign rd_addr = ROW_W'(i_query_row);

    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            fill_mask[j] = (32'(j) >= 32'(r_col)) && (32'(j) < 32'(r_col) + 32'(r_cs));
        end
        // a row never written takes zeros in its other lanes
        fill_we     = r_row_vld[r_row] ? fill_mask : '1;
        query_owner = (r_qin && r_rd_vld) ? r_rd_data[COL_W'(r_qcol)] : '0;
    end

    // row memory of owner ids
    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            for (int j = 0; j < MAX_COLS; j++) begin
                if (fill_we[j]) begin
                    r_owner_mem[r_row][j] <= fill_mask[j] ? r_owner : '0;
                end
            end
        end
        r_rd_data <= r_owner_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rows_in_use <= gffba_pkg::ROWS_RESET;
            r_cols_in_use <= gffba_pkg::COLS_RESET;
            r_occ         <= '0;
            r_row_vld     <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[rd_addr];

            if (i_cfg_we) begin
                unique case (gffba_pkg::t_cfg_index'(i_cfg_index))
                    gffba_pkg::CFG_ROWS_IN_USE: begin
                        r_rows_in_use <= i_cfg_data;
                    end
                    gffba_pkg::CFG_COLS_IN_USE: begin
                        r_cols_in_use <= i_cfg_data[gffba_pkg::COLS_CFG_W-1:0];
                    end
                endcase
                r_occ     <= '0;
                r_row_vld <= '0;
            end

            if (out_take && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_res_found <= 1'b0;
                    r_res_row   <= '0;
                    r_res_col   <= '0;
                    r_res_owner <= '0;
                    if (in_accept) begin
                        unique case (gffba_pkg::t_action'(i_action))
                            gffba_pkg::ACT_CLEAR: begin
                                r_occ     <= '0;
                                r_row_vld <= '0;
                                r_state   <= S_DONE;
                            end
                            gffba_pkg::ACT_PLACE: begin
                                r_rs    <= i_blk_rows;
                                r_cs    <= i_blk_cols;
                                r_owner <= OWNER_BITS'(i_owner_id);
                                r_row   <= '0;
                                r_run   <= '0;
                                if ((i_blk_rows == '0) || (i_blk_cols == '0) ||
                                    (area_rows == '0) || (area_cols == '0)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            gffba_pkg::ACT_QUERY: begin
                                r_qcol  <= i_query_col;
                                r_qin   <= (32'(i_query_row) < MAX_ROWS) &&
                                           (32'(i_query_col) < MAX_COLS);
                                r_state <= S_QUERY;
                            end
                            gffba_pkg::ACT_NONE: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_run <= n_run;
                    priority if (hit) begin
                        r_row       <= hit_top;
                        r_end       <= r_row;
                        r_col       <= hit_col;
                        r_res_row   <= gffba_pkg::PLACE_ROW_W'(hit_top);
                        r_res_col   <= gffba_pkg::PLACE_COL_W'(hit_col);
                        r_state     <= S_FILL;
                    end else if (32'(r_row) + 32'd1 >= 32'(area_rows)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                S_FILL: begin
                    r_row_vld[r_row] <= 1'b1;
                    if (r_owner != '0) begin
                        r_occ[r_row] <= r_occ[r_row] | fill_mask;
                    end
                    if (r_row == r_end) begin
                        r_res_found <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                S_QUERY: begin
                    r_res_owner <= gffba_pkg::OWNER_W'(query_owner);
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_row   <= r_res_row;
                        r_out_col   <= r_res_col;
                        r_out_owner <= r_res_owner;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted without leaving idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word loaded outside done state");

    a_fill_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_row <= r_end))
        else $error("fill row past bottom of block");

    a_hit_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit) |-> (32'(r_row) + 32'd1 >= 32'(r_rs)))
        else $error("hit before enough rows scanned");

endmodule

`default_nettype wire

>>> tb/gffba_tb_pkg.sv
// ----------------------------------------------------------------------------
// gffba_tb_pkg
// Word types and the result checker for the grid allocator testbench. The
// checker keeps its own occupancy grid and register copies, predicts the
// result of every accepted request word and compares it with the result
// words in order.
// ----------------------------------------------------------------------------
package gffba_tb_pkg;

    import gffba_pkg::*;

    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 4;

    typedef struct packed {
        t_action                  action;
        logic [BLK_ROWS_W-1:0]    blk_rows;
        logic [BLK_COLS_W-1:0]    blk_cols;
        logic [OWNER_W-1:0]       owner_id;
        logic [QUERY_ROW_W-1:0]   query_row;
        logic [QUERY_COL_W-1:0]   query_col;
    } t_alloc_word;

    typedef struct packed {
        logic                     found;
        logic [PLACE_ROW_W-1:0]   place_row;
        logic [PLACE_COL_W-1:0]   place_col;
        logic [OWNER_W-1:0]       cell_owner;
    } t_alloc_outcome;

    class alloc_checker;
        logic [OWNER_W-1:0]    cells [GRID_ROWS][GRID_COLS];
        logic [ROWS_CFG_W-1:0] rows_in_use;
        logic [COLS_CFG_W-1:0] cols_in_use;
        t_alloc_outcome        pending_outcomes [$];
        int                    errors;

        function new();
            free_grid();
            rows_in_use = ROWS_RESET;
            cols_in_use = COLS_RESET;
            errors = 0;
        endfunction

        function void free_grid();
            foreach (cells[r, c]) cells[r][c] = '0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROWS_IN_USE) begin
                rows_in_use = data[ROWS_CFG_W-1:0];
            end else begin
                cols_in_use = data[COLS_CFG_W-1:0];
            end
            free_grid();
        endfunction

        function bit block_free(int top, int left, int rs, int cs, int nr, int nc);
            if (top + rs > nr || left + cs > nc) return 1'b0;
            for (int i = 0; i < rs; i++)
                for (int j = 0; j < cs; j++)
                    if (cells[top + i][left + j] != '0) return 1'b0;
            return 1'b1;
        endfunction

        function t_alloc_outcome predict_outcome(t_alloc_word w);
            t_alloc_outcome res;
            int nr;
            int nc;
            int rs;
            int cs;
            res = '0;
            rs = w.blk_rows;
            cs = w.blk_cols;
            case (w.action)
                ACT_CLEAR: begin
                    free_grid();
                end
                ACT_PLACE: begin
                    nr = (rows_in_use > GRID_ROWS) ? GRID_ROWS : rows_in_use;
                    nc = (cols_in_use > GRID_COLS) ? GRID_COLS : cols_in_use;
                    if (rs != 0 && cs != 0) begin
                        for (int r = 0; r < nr && !res.found; r++)
                            for (int c = 0; c < nc && !res.found; c++)
                                if (block_free(r, c, rs, cs, nr, nc)) begin
                                    res.found = 1'b1;
                                    res.place_row = PLACE_ROW_W'(r);
                                    res.place_col = PLACE_COL_W'(c);
                                end
                    end
                    if (res.found) begin
                        for (int i = 0; i < rs; i++)
                            for (int j = 0; j < cs; j++)
                                cells[int'(res.place_row) + i][int'(res.place_col) + j] =
                                    w.owner_id;
                    end
                end
                ACT_QUERY: begin
                    res.cell_owner = cells[w.query_row][w.query_col];
                end
                default: begin
                end
            endcase
            return res;
        endfunction

        function void note_request(t_alloc_word w);
            pending_outcomes.push_back(predict_outcome(w));
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void compare_field(string name, logic [OWNER_W-1:0] want,
                                    logic [OWNER_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(t_alloc_outcome got);
            t_alloc_outcome want;
            if (pending_outcomes.size() == 0) begin
                $error("result word with no request pending");
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("found", OWNER_W'(want.found), OWNER_W'(got.found));
            compare_field("place_row", OWNER_W'(want.place_row), OWNER_W'(got.place_row));
            compare_field("place_col", OWNER_W'(want.place_col), OWNER_W'(got.place_col));
            compare_field("cell_owner", want.cell_owner, got.cell_owner);
        endfunction
    endclass

endpackage

>>> tb/tb_grid_first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_grid_first_fit_block_allocator_unit
// Drives place, query, clear and unused request words through the allocator
// under bursty input and random output stall, across a series of grid sizes
// including zero and over-range settings, and checks every result word
// against a predicted occupancy grid.
// ----------------------------------------------------------------------------
module tb_grid_first_fit_block_allocator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import gffba_pkg::*;
    import gffba_tb_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PLANNED_PHASES  = 9;
    localparam int TOTAL_PHASES    = 12;
    localparam int ROWS_PLAN [PLANNED_PHASES] = '{1, 16, 0, 31, 16, 5, 12, 3, 16};
    localparam int COLS_PLAN [PLANNED_PHASES] = '{1, 4, 4, 31, 0, 3, 2, 4, 4};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ACTION_W-1:0]      i_action = '0;
    logic [BLK_ROWS_W-1:0]    i_blk_rows = '0;
    logic [BLK_COLS_W-1:0]    i_blk_cols = '0;
    logic [OWNER_W-1:0]       i_owner_id = '0;
    logic [QUERY_ROW_W-1:0]   i_query_row = '0;
    logic [QUERY_COL_W-1:0]   i_query_col = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_found;
    logic [PLACE_ROW_W-1:0]   o_place_row;
    logic [PLACE_COL_W-1:0]   o_place_col;
    logic [OWNER_W-1:0]       o_cell_owner;

    alloc_checker sb = new();

    int burst_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int run_left = 0;
    int idle_cycles = 0;

    grid_first_fit_block_allocator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_blk_rows   (i_blk_rows),
        .i_blk_cols   (i_blk_cols),
        .i_owner_id   (i_owner_id),
        .i_query_row  (i_query_row),
        .i_query_col  (i_query_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_place_row  (o_place_row),
        .o_place_col  (o_place_col),
        .o_cell_owner (o_cell_owner)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_alloc_word make_word(t_action act, int rs, int cs, int own,
                                              int qr, int qc);
        t_alloc_word w;
        w.action    = act;
        w.blk_rows  = BLK_ROWS_W'(rs);
        w.blk_cols  = BLK_COLS_W'(cs);
        w.owner_id  = OWNER_W'(own);
        w.query_row = QUERY_ROW_W'(qr);
        w.query_col = QUERY_COL_W'(qc);
        return w;
    endfunction

    function automatic t_alloc_word random_word();
        t_alloc_word w;
        int pick;
        int span;
        w = make_word(ACT_NONE, $urandom_range(0, 31), $urandom_range(0, 7),
                      $urandom_range(1, 255), $urandom_range(0, 15), $urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            w.action = ACT_PLACE;
            span = $urandom_range(0, 99);
            if (span < 60) begin
                w.blk_rows = BLK_ROWS_W'($urandom_range(1, 3));
                w.blk_cols = BLK_COLS_W'($urandom_range(1, 2));
            end else if (span < 85) begin
                w.blk_rows = BLK_ROWS_W'($urandom_range(1, 16));
                w.blk_cols = BLK_COLS_W'($urandom_range(1, 4));
            end
            if ($urandom_range(0, 19) == 0) w.owner_id = '0;
        end else if (pick < 88) begin
            w.action = ACT_QUERY;
        end else if (pick < 95) begin
            w.action = ACT_CLEAR;
        end else begin
            w.action = ACT_NONE;
            if ($urandom_range(0, 1) == 0) w.owner_id = '0;
        end
        return w;
    endfunction

    task automatic send_word(t_alloc_word w);
        i_in_valid  <= 1'b1;
        i_action    <= w.action;
        i_blk_rows  <= w.blk_rows;
        i_blk_cols  <= w.blk_cols;
        i_owner_id  <= w.owner_id;
        i_query_row <= w.query_row;
        i_query_col <= w.query_col;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(w);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_grid_size(int rows, int cols);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS_IN_USE;
        i_cfg_data  <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        sb.write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(rows));
        i_cfg_index <= CFG_COLS_IN_USE;
        i_cfg_data  <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        sb.write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(cols));
        i_cfg_we    <= 1'b0;
    endtask

    // output side: check each accepted word, stall in changing modes
    always @(posedge i_clk) begin : result_side
        t_alloc_outcome got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.found      = o_found;
                got.place_row  = o_place_row;
                got.place_col  = o_place_col;
                got.cell_owner = o_cell_owner;
                sb.check_outcome(got);
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (run_left == 0) begin
                        i_out_stall <= !i_out_stall;
                        run_left = $urandom_range(1, 20);
                    end else begin
                        run_left--;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_grid_first_fit_block_allocator_unit: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int rows;
        int cols;
        while (!i_rst_n) @(posedge i_clk);

        // full grid after reset
        send_word(make_word(ACT_QUERY, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_PLACE, 0, 1, 1, 0, 0));
        send_word(make_word(ACT_PLACE, 1, 0, 1, 0, 0));
        send_word(make_word(ACT_PLACE, 16, 4, 255, 0, 0));
        send_word(make_word(ACT_QUERY, 0, 0, 0, 15, 3));
        send_word(make_word(ACT_PLACE, 1, 1, 2, 0, 0));
        send_word(make_word(ACT_CLEAR, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_PLACE, 17, 1, 3, 0, 0));
        send_word(make_word(ACT_PLACE, 1, 5, 3, 0, 0));
        send_word(make_word(ACT_PLACE, 31, 7, 255, 15, 3));
        send_word(make_word(ACT_PLACE, 2, 2, 0, 0, 0));
        send_word(make_word(ACT_QUERY, 0, 0, 0, 1, 1));
        send_word(make_word(ACT_PLACE, 1, 1, 1, 0, 0));
        send_word(make_word(ACT_PLACE, 2, 3, 170, 0, 0));
        send_word(make_word(ACT_PLACE, 1, 4, 85, 0, 0));
        send_word(make_word(ACT_QUERY, 0, 0, 0, 0, 1));
        send_word(make_word(ACT_QUERY, 0, 0, 0, 2, 3));
        send_word(make_word(ACT_NONE, 31, 7, 255, 15, 3));
        send_word(make_word(ACT_PLACE, 16, 1, 9, 0, 0));
        send_word(make_word(ACT_PLACE, 13, 4, 128, 0, 0));
        send_word(make_word(ACT_QUERY, 31, 7, 255, 15, 0));
        send_word(make_word(ACT_CLEAR, 31, 7, 255, 15, 3));
        send_word(make_word(ACT_QUERY, 0, 0, 0, 15, 0));
        wait_idle();

        for (int p = 0; p < TOTAL_PHASES; p++) begin
            if (p < PLANNED_PHASES) begin
                rows = ROWS_PLAN[p];
                cols = COLS_PLAN[p];
            end else begin
                rows = $urandom_range(0, 31);
                cols = $urandom_range(0, 31);
            end
            write_grid_size(rows, cols);
            repeat (ITEMS_PER_PHASE) send_word(random_word());
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("tb_grid_first_fit_block_allocator_unit: PASS");
        end else begin
            $display("tb_grid_first_fit_block_allocator_unit: FAIL");
        end
        $finish;
    end

endmodule
